/* design/bbc_lru_pkg.sv */
// ============================================================================
// bbc_lru_pkg: shared types and codes for the buffer cache LRU manager
// Function codes, status codes and the sequencer state type.
// ============================================================================
package bbc_lru_pkg;

    localparam int DefNumBuffers = 16;

    typedef enum logic [1:0] {
        FUNC_GET     = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_IODONE  = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BUSY    = 3'd1,
        ST_NOBUF   = 3'd2,
        ST_NOTBUSY = 3'd3,
        ST_IOERR   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HIT_RD,
        S_HIT_CHK,
        S_VIC_RD,
        S_VIC_CHK,
        S_PROMOTE,
        S_DONE
    } state_t;

endpackage

/* design/block_buffer_cache_lru_manager.sv */
// ============================================================================
// block_buffer_cache_lru_manager
// Tag and LRU replacement manager for a fixed pool of block buffers.
// ============================================================================
// One request is taken at a time. in_stall stays high from the accepting
// edge until the sequencer is idle again. The tag store (owner, block, size)
// sits in a synchronous memory with one read port. Marks and LRU ranks sit
// in flip-flops, with an order list that maps rank to entry. A get reads the
// tag memory once per rank, MRU first, with an address state (S_HIT_RD) and
// then a compare state (S_HIT_CHK) per rank. A miss then walks the order
// list from the LRU end at one entry per cycle, and S_PROMOTE moves the
// claimed entry to MRU. S_DONE loads the result. A release, a completion or
// an unknown code goes from idle straight to S_HIT_CHK and then to S_DONE.
// The ranks and the order list are updated together on a move to MRU. A
// finished result waits in the output register; while it is stalled the
// next request is processed, and its result is held until the register
// frees.
module block_buffer_cache_lru_manager
    import bbc_lru_pkg::*;
#(
    parameter int NUM_BUFFERS = DefNumBuffers
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [15:0] owner_id,
    input  logic [31:0] block_number,
    input  logic [15:0] request_size,
    input  logic [3:0]  buffer_index,
    input  logic        io_error,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [3:0]  result_index,
    output logic        cache_hit,
    output logic        size_mismatch,
    output logic        wake_waiter
);
    localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int CW = IW + 1;
    localparam int TW = 64;

    // tag memory: {owner, block, size}
    logic [TW-1:0] tag_mem [NUM_BUFFERS];
    logic [TW-1:0] tag_rd_reg;
    logic          tag_we;
    logic [IW-1:0] tag_waddr, tag_raddr;
    logic [TW-1:0] tag_wdata;

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        tag_rd_reg <= tag_mem[tag_raddr];
    end

    // marks, ranks and rank->entry order list
    logic [NUM_BUFFERS-1:0] asg_reg, busy_reg, inv_reg, want_reg;
    logic [NUM_BUFFERS-1:0] asg_next, busy_next, inv_next, want_next;
    logic [IW-1:0] rank_reg [NUM_BUFFERS];
    logic [IW-1:0] order_reg [NUM_BUFFERS];

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] ent_reg, ent_next;
    logic [1:0]    func_reg;
    logic [15:0]   own_reg, size_reg;
    logic [31:0]   blk_reg;
    logic [3:0]    idx_reg;
    logic          err_reg;
    logic          mis_reg, mis_next;
    logic          promote;
    logic [IW-1:0] prom_ent;

    logic          ov_reg, ov_next;
    logic [2:0]    st_reg, st_next;
    logic [3:0]    ri_reg, ri_next;
    logic          hit_reg, hit_next, smis_reg, smis_next, wake_reg, wake_next;

    logic          idx_ok;
    logic [IW-1:0] idx_e;
    logic [IW-1:0] ord_e;

    assign idx_ok = ({28'd0, idx_reg} < 32'(NUM_BUFFERS));
    assign idx_e  = IW'(idx_reg);
    assign ord_e  = order_reg[cnt_reg[IW-1:0]];

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = ov_reg;
    assign status       = st_reg;
    assign result_index = ri_reg;
    assign cache_hit    = hit_reg;
    assign size_mismatch = smis_reg;
    assign wake_waiter  = wake_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ent_next   = ent_reg;
        mis_next   = mis_reg;
        asg_next   = asg_reg;
        busy_next  = busy_reg;
        inv_next   = inv_reg;
        want_next  = want_reg;
        ov_next    = ov_reg && out_stall;
        st_next    = st_reg;
        ri_next    = ri_reg;
        hit_next   = hit_reg;
        smis_next  = smis_reg;
        wake_next  = wake_reg;
        promote    = 1'b0;
        prom_ent   = ent_reg;
        tag_we     = 1'b0;
        tag_waddr  = ent_reg;
        tag_wdata  = {own_reg, blk_reg, size_reg};
        tag_raddr  = ord_e;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cnt_next = '0;
                    mis_next = 1'b0;
                    priority case (func_t'(func))
                        FUNC_GET:     state_next = S_HIT_RD;
                        default:      state_next = S_HIT_CHK;
                    endcase
                end
            end
            S_HIT_RD:
            begin
                // address for rank cnt already on tag_raddr
                ent_next   = ord_e;
                state_next = S_HIT_CHK;
            end
            S_HIT_CHK:
            begin
                if (func_reg == FUNC_GET)
                begin
                    if (asg_reg[ent_reg] && !inv_reg[ent_reg] &&
                        tag_rd_reg[63:16] == {own_reg, blk_reg})
                    begin
                        if (busy_reg[ent_reg])
                        begin
                            want_next[ent_reg] = 1'b1;
                            st_next = ST_BUSY; ri_next = 4'(ent_reg);
                            hit_next = 1'b1; smis_next = 1'b0; wake_next = 1'b0;
                            state_next = S_DONE;
                        end
                        else if (tag_rd_reg[15:0] == size_reg)
                        begin
                            busy_next[ent_reg] = 1'b1;
                            st_next = ST_OK; ri_next = 4'(ent_reg);
                            hit_next = 1'b1; smis_next = 1'b0; wake_next = 1'b0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            inv_next[ent_reg]  = 1'b1;
                            want_next[ent_reg] = 1'b0;
                            promote  = 1'b1;
                            mis_next = 1'b1;
                            cnt_next = CW'(NUM_BUFFERS - 1);
                            state_next = S_VIC_RD;
                        end
                    end
                    else if (cnt_reg == CW'(NUM_BUFFERS - 1))
                    begin
                        cnt_next   = CW'(NUM_BUFFERS - 1);
                        state_next = S_VIC_RD;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_HIT_RD;
                    end
                end
                else
                begin
                    // release, completion, unknown code
                    st_next = ST_OK; ri_next = idx_reg;
                    hit_next = 1'b0; smis_next = 1'b0; wake_next = 1'b0;
                    prom_ent = idx_e;
                    state_next = S_DONE;
                    unique case (func_t'(func_reg))
                        FUNC_RELEASE:
                        begin
                            if (!idx_ok || !busy_reg[idx_e])
                            begin
                                st_next = ST_NOTBUSY;
                            end
                            else
                            begin
                                wake_next = want_reg[idx_e];
                                want_next[idx_e] = 1'b0;
                                busy_next[idx_e] = 1'b0;
                                promote = 1'b1;
                            end
                        end
                        FUNC_IODONE:
                        begin
                            if (err_reg)
                            begin
                                st_next = ST_IOERR;
                                if (idx_ok && !inv_reg[idx_e])
                                begin
                                    inv_next[idx_e] = 1'b1;
                                    promote = 1'b1;
                                end
                            end
                        end
                        FUNC_GET, FUNC_NONE:
                        begin
                            ri_next = 4'd0;
                        end
                    endcase
                end
            end
            S_VIC_RD:
            begin
                // walk from the LRU end; order list is flip-flops
                if (!busy_reg[ord_e])
                begin
                    ent_next = ord_e;
                    busy_next[ord_e] = 1'b1;
                    want_next[ord_e] = 1'b0;
                    inv_next[ord_e]  = 1'b0;
                    asg_next[ord_e]  = 1'b1;
                    tag_we    = 1'b1;
                    tag_waddr = ord_e;
                    state_next = S_PROMOTE;
                end
                else if (cnt_reg == '0)
                begin
                    st_next = ST_NOBUF; ri_next = 4'd0;
                    hit_next = 1'b0; smis_next = mis_reg; wake_next = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_PROMOTE:
            begin
                promote = 1'b1;
                st_next = ST_OK; ri_next = 4'(ent_reg);
                hit_next = 1'b0; smis_next = mis_reg; wake_next = 1'b0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // results are staged in *_next but only take effect at S_DONE commit
    logic [2:0] pst_reg;
    logic [3:0] pri_reg;
    logic       phit_reg, psm_reg, pwk_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg != S_DONE)
        begin
            pst_reg  <= st_next;
            pri_reg  <= ri_next;
            phit_reg <= hit_next;
            psm_reg  <= smis_next;
            pwk_reg  <= wake_next;
        end
        if (state_reg == S_DONE && (!ov_reg || !out_stall))
        begin
            st_reg   <= pst_reg;
            ri_reg   <= pri_reg;
            hit_reg  <= phit_reg;
            smis_reg <= psm_reg;
            wake_reg <= pwk_reg;
        end
        if (state_reg == S_IDLE && in_valid)
        begin
            func_reg <= func;
            own_reg  <= owner_id;
            blk_reg  <= block_number;
            size_reg <= request_size;
            idx_reg  <= buffer_index;
            err_reg  <= io_error;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ent_reg   <= '0;
            mis_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            asg_reg   <= '0;
            busy_reg  <= '0;
            inv_reg   <= '0;
            want_reg  <= '0;
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                rank_reg[i]  <= IW'(i);
                order_reg[i] <= IW'(i);
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ent_reg   <= ent_next;
            mis_reg   <= mis_next;
            ov_reg    <= ov_next;
            asg_reg   <= asg_next;
            busy_reg  <= busy_next;
            inv_reg   <= inv_next;
            want_reg  <= want_next;
            if (promote)
            begin
                // advance every entry ranked ahead of the promoted one
                for (int i = 0; i < NUM_BUFFERS; i++)
                begin
                    if (rank_reg[i] < rank_reg[prom_ent])
                    begin
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                    end
                    if (IW'(i) <= rank_reg[prom_ent] && i > 0)
                    begin
                        order_reg[i] <= order_reg[i-1];
                    end
                end
                rank_reg[prom_ent] <= '0;
                order_reg[0]       <= prom_ent;
            end
        end
    end

endmodule

/* design/bbc_lru_checker.sv */
// ============================================================================
// bbc_lru_checker: port-level checks for the buffer cache LRU manager
// Watches the result channel of the top level.
// ============================================================================
module bbc_lru_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] status,
    input logic [3:0] result_index,
    input logic       cache_hit,
    input logic       size_mismatch
);
    import bbc_lru_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_IOERR)
        else $error("status out of range");

    a_hit_mis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(cache_hit && size_mismatch))
        else $error("hit and size mismatch together");

    a_nobuf_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_NOBUF |-> result_index == 4'd0)
        else $error("no-buffer result with nonzero index");

    a_busy_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_BUSY |-> cache_hit)
        else $error("busy status without hit");
endmodule

bind block_buffer_cache_lru_manager bbc_lru_checker u_bbc_lru_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .result_index(result_index), .cache_hit(cache_hit),
    .size_mismatch(size_mismatch)
);

/* bench/tb_block_buffer_cache_lru_manager.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_block_buffer_cache_lru_manager: self-checking bench for the LRU manager
// Drives get, release and completion requests through the valid/stall
// handshake and checks every result against a cycle-free model of the tag
// store and LRU order kept inside the bench.
// ============================================================================
module tb_block_buffer_cache_lru_manager;
    import bbc_lru_pkg::*;

    localparam int NBUF      = DefNumBuffers;
    localparam int IDLE_LIMIT = 5000;   // cycles with no transfer on either side
    localparam int TAIL_WAIT  = 60;     // settle time after the last result

    typedef struct {
        status_t    st;
        logic [3:0] idx;
        bit         hit;
        bit         mis;
        bit         wake;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [15:0] owner_id;
    logic [31:0] block_number;
    logic [15:0] request_size;
    logic [3:0]  buffer_index;
    logic        io_error;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [3:0]  result_index;
    logic        cache_hit;
    logic        size_mismatch;
    logic        wake_waiter;

    // Cache model: identity, marks and LRU rank per entry (rank 0 is MRU).
    logic [31:0] tag_block [NBUF];
    logic [15:0] tag_owner [NBUF];
    logic [15:0] tag_size  [NBUF];
    bit          is_assigned [NBUF];
    bit          is_locked   [NBUF];
    bit          is_invalid  [NBUF];
    bit          is_wanted   [NBUF];
    int          lru_pos     [NBUF];

    answer_t pending_answers[$];

    int errors        = 0;
    int sent_items    = 0;
    int got_results   = 0;
    int n_hits        = 0;
    int n_nobuf       = 0;
    int n_wakes       = 0;
    int n_mismatch    = 0;
    int quiet_cycles  = 0;
    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    int hold_off_cycles   = 0;

    block_buffer_cache_lru_manager i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .owner_id     (owner_id),
        .block_number (block_number),
        .request_size (request_size),
        .buffer_index (buffer_index),
        .io_error     (io_error),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .result_index (result_index),
        .cache_hit    (cache_hit),
        .size_mismatch(size_mismatch),
        .wake_waiter  (wake_waiter)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------------
    // Cache model
    // ------------------------------------------------------------------------
    function automatic void move_to_front(int e);
        int old;
        old = lru_pos[e];
        for (int i = 0; i < NBUF; i++)
        begin
            if (lru_pos[i] < old)
                lru_pos[i]++;
        end
        lru_pos[e] = 0;
    endfunction

    function automatic int entry_at_rank(int r);
        for (int i = 0; i < NBUF; i++)
        begin
            if (lru_pos[i] == r)
                return i;
        end
        return NBUF;
    endfunction

    function automatic answer_t lookup_or_claim(logic [15:0] own, logic [31:0] blk,
                                               logic [15:0] sz);
        answer_t a;
        int e;
        bit mis;
        a = '{ST_OK, 4'd0, 0, 0, 0};
        mis = 0;
        // hit search, most recently used first
        for (int r = 0; r < NBUF; r++)
        begin
            e = entry_at_rank(r);
            if (e < NBUF && is_assigned[e] && !is_invalid[e] &&
                tag_owner[e] == own && tag_block[e] == blk)
            begin
                if (is_locked[e])
                begin
                    is_wanted[e] = 1;
                    a.st = ST_BUSY; a.idx = e[3:0]; a.hit = 1;
                    return a;
                end
                if (tag_size[e] == sz)
                begin
                    is_locked[e] = 1;
                    a.st = ST_OK; a.idx = e[3:0]; a.hit = 1;
                    return a;
                end
                // wrong size: drop the stale copy and fall through to a miss
                is_invalid[e] = 1;
                is_wanted[e]  = 0;
                move_to_front(e);
                mis = 1;
                break;
            end
        end
        a.mis = mis;
        // victim search from the LRU end
        for (int r = NBUF - 1; r >= 0; r--)
        begin
            e = entry_at_rank(r);
            if (e < NBUF && !is_locked[e])
            begin
                is_locked[e]   = 1;
                is_wanted[e]   = 0;
                is_invalid[e]  = 0;
                is_assigned[e] = 1;
                tag_owner[e]   = own;
                tag_block[e]   = blk;
                tag_size[e]    = sz;
                move_to_front(e);
                a.idx = e[3:0];
                return a;
            end
        end
        a.st = ST_NOBUF;
        return a;
    endfunction

    function automatic answer_t cache_answer(func_t f, logic [15:0] own, logic [31:0] blk,
                                            logic [15:0] sz, logic [3:0] idx, logic err);
        answer_t a;
        a = '{ST_OK, idx, 0, 0, 0};
        case (f)
            FUNC_GET:
                a = lookup_or_claim(own, blk, sz);
            FUNC_RELEASE:
            begin
                if (!is_locked[idx])
                    a.st = ST_NOTBUSY;
                else
                begin
                    a.wake = is_wanted[idx];
                    is_wanted[idx] = 0;
                    is_locked[idx] = 0;
                    move_to_front(idx);
                end
            end
            FUNC_IODONE:
            begin
                if (err)
                begin
                    if (!is_invalid[idx])
                    begin
                        is_invalid[idx] = 1;
                        move_to_front(idx);
                    end
                    a.st = ST_IOERR;
                end
            end
            default:
                a = '{ST_OK, 4'd0, 0, 0, 0};
        endcase
        return a;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one transfer per call, at random with an idle gap ahead of it
    // ------------------------------------------------------------------------
    task automatic send_request(func_t f, logic [15:0] own, logic [31:0] blk,
                                logic [15:0] sz, logic [3:0] idx, logic err);
        answer_t a;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        owner_id     <= own;
        block_number <= blk;
        request_size <= sz;
        buffer_index <= idx;
        io_error     <= err;
        // inputs settle after the edge; the transfer happens at the next
        // rising edge seen with stall low at the falling edge before it
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        a = cache_answer(f, own, blk, sz, idx, err);
        pending_answers.push_back(a);
        sent_items++;
    endtask

    // Drop valid right at the last transfer edge, then wait for the results.
    task automatic wait_all_answered();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver stall: random per phase, or a long hold-off when requested
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Result checker and watchdog: sample at the falling edge, where all
    // handshake signals are stable for the coming rising edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        answer_t a;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("tb_block_buffer_cache_lru_manager: errors");
                $finish;
            end
            if (out_valid && !out_stall)
            begin
                got_results++;
                if (pending_answers.size() == 0)
                begin
                    $error("unexpected result: status %0d index %0d", status, result_index);
                    errors++;
                end
                else
                begin
                    a = pending_answers.pop_front();
                    if (status !== a.st)
                    begin
                        $error("status: expected %0d, got %0d", a.st, status);
                        errors++;
                    end
                    if (result_index !== a.idx)
                    begin
                        $error("result_index: expected %0d, got %0d", a.idx, result_index);
                        errors++;
                    end
                    if (cache_hit !== a.hit)
                    begin
                        $error("cache_hit: expected %0d, got %0d", a.hit, cache_hit);
                        errors++;
                    end
                    if (size_mismatch !== a.mis)
                    begin
                        $error("size_mismatch: expected %0d, got %0d", a.mis, size_mismatch);
                        errors++;
                    end
                    if (wake_waiter !== a.wake)
                    begin
                        $error("wake_waiter: expected %0d, got %0d", a.wake, wake_waiter);
                        errors++;
                    end
                    n_hits     += a.hit;
                    n_mismatch += a.mis;
                    n_wakes    += a.wake;
                    n_nobuf    += (a.st == ST_NOBUF);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Miss, hit on a locked entry, release waking the waiter, release of a free
    // entry, clean hit, release, a wrong-size hit, then a miss with every field high.
    task automatic test_hit_paths();
        send_request(FUNC_GET, 16'h0001, 32'h0000_0010, 16'd1024, 4'd0, 1'b0);
        send_request(FUNC_GET, 16'h0001, 32'h0000_0010, 16'd1024, 4'd0, 1'b0);
        send_request(FUNC_RELEASE, 16'h0, 32'h0, 16'h0, 4'd15, 1'b0);
        send_request(FUNC_RELEASE, 16'h0, 32'h0, 16'h0, 4'd15, 1'b0);
        send_request(FUNC_GET, 16'h0001, 32'h0000_0010, 16'd1024, 4'd0, 1'b0);
        send_request(FUNC_RELEASE, 16'h0, 32'h0, 16'h0, 4'd15, 1'b0);
        send_request(FUNC_GET, 16'h0001, 32'h0000_0010, 16'd2048, 4'd0, 1'b0);
        send_request(FUNC_GET, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'd0, 1'b0);
    endtask

    // Completions with and without error, on invalid and valid entries,
    // plus the unused function code with every field high.
    task automatic test_completion_and_odd_code();
        send_request(FUNC_IODONE, 16'h0, 32'h0, 16'h0, 4'd14, 1'b1);
        send_request(FUNC_IODONE, 16'h0, 32'h0, 16'h0, 4'd14, 1'b1);
        send_request(FUNC_IODONE, 16'h0, 32'h0, 16'h0, 4'd3, 1'b0);
        send_request(FUNC_NONE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'd15, 1'b1);
        send_request(FUNC_GET, 16'h0000, 32'h0000_0000, 16'h0000, 4'd0, 1'b0);
    endtask

    // Lock every entry, then a get finds no free buffer; free them again.
    task automatic test_pool_exhaustion();
        for (int i = 0; i < NBUF; i++)
            send_request(FUNC_GET, 16'h00A0, 32'(i + 100), 16'd512, 4'd0, 1'b0);
        send_request(FUNC_GET, 16'h00A0, 32'd999, 16'd512, 4'd0, 1'b0);
        for (int i = 0; i < NBUF; i++)
            send_request(FUNC_RELEASE, 16'h0, 32'h0, 16'h0, 4'(i), 1'b0);
    endtask

    // Mostly well-formed traffic over a small working set so that hits,
    // waits, wakes and exhaustion all recur; the rest is full-range noise.
    task automatic send_random_request();
        int pick;
        int locked_list[$];
        logic [15:0] own;
        logic [31:0] blk;
        logic [15:0] sz;
        logic [3:0]  idx;
        logic        err;
        pick = $urandom_range(99);
        own  = 16'($urandom_range(3));
        blk  = $urandom_range(23);
        sz   = $urandom_range(1) ? 16'd512 : 16'd4096;
        idx  = 4'($urandom_range(15));
        err  = 1'($urandom_range(1));
        if ($urandom_range(9) == 0)
        begin
            own = 16'($urandom);
            blk = $urandom;
            sz  = 16'($urandom);
        end
        if (pick < 55)
            send_request(FUNC_GET, own, blk, sz, idx, err);
        else if (pick < 85)
        begin
            for (int i = 0; i < NBUF; i++)
            begin
                if (is_locked[i])
                    locked_list.push_back(i);
            end
            if (locked_list.size() != 0 && $urandom_range(4) != 0)
                idx = 4'(locked_list[$urandom_range(locked_list.size() - 1)]);
            send_request(FUNC_RELEASE, own, blk, sz, idx, err);
        end
        else if (pick < 97)
            send_request(FUNC_IODONE, own, blk, sz, idx, err);
        else
            send_request(FUNC_NONE, own, blk, sz, idx, err);
    endtask

    task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) send_random_request();
        wait_all_answered();
    endtask

    // Hold the receiver off long enough for the block to back up into its
    // input while the sender keeps offering, then let everything drain.
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_cycles    = 300;
        repeat (30) send_random_request();
        wait_all_answered();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = FUNC_GET;
        owner_id     = '0;
        block_number = '0;
        request_size = '0;
        buffer_index = '0;
        io_error     = 1'b0;
        for (int i = 0; i < NBUF; i++)
        begin
            tag_block[i]   = '0;
            tag_owner[i]   = '0;
            tag_size[i]    = '0;
            is_assigned[i] = 0;
            is_locked[i]   = 0;
            is_invalid[i]  = 0;
            is_wanted[i]   = 0;
            lru_pos[i]     = i;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_hit_paths();
        test_completion_and_odd_code();
        test_pool_exhaustion();
        wait_all_answered();

        test_random_traffic(400, 0, 0);
        test_random_traffic(380, 48, 0);
        test_backpressure();
        test_random_traffic(380, 0, 48);
        test_random_traffic(360, 15, 15);

        wait_all_answered();
        repeat (TAIL_WAIT) @(posedge clk);

        $display("Covered %0d requests and %0d results: %0d hits, %0d size mismatches,",
                 sent_items, got_results, n_hits, n_mismatch);
        $display("%0d waiter wakes, %0d pool-exhausted gets.", n_wakes, n_nobuf);
        if (errors == 0 && pending_answers.size() == 0)
            $display("tb_block_buffer_cache_lru_manager: clean");
        else
            $display("tb_block_buffer_cache_lru_manager: errors");
        $finish;
    end

endmodule

/* block_buffer_cache_lru_manager.f */
design/bbc_lru_pkg.sv
design/block_buffer_cache_lru_manager.sv
design/bbc_lru_checker.sv
bench/tb_block_buffer_cache_lru_manager.sv
